// ----- src/kvi_pkg.sv -----
// Package: shared constants, payload types and state encoding for the keyframe interpolator.
package kvi_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int KC_W      = 5;
  localparam int SLOT_W    = 4;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int FACTOR_W  = FRAC_W + 1;
  localparam int PROD_W    = FACTOR_W + DATA_W + 2;
  localparam int STEP_W    = $clog2(FRAC_W);
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_W;

  typedef enum logic {
    CMD_STORE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } kvi_cmd_t;

  typedef struct packed {
    kvi_cmd_t                  command;
    logic [SLOT_W-1:0]         key_slot;
    logic [DATA_W-1:0]         key_time;
    logic signed [DATA_W-1:0]  key_x;
    logic signed [DATA_W-1:0]  key_y;
    logic signed [DATA_W-1:0]  key_z;
    logic [DATA_W-1:0]         query_time;
  } kvi_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_x;
    logic signed [DATA_W-1:0]  out_y;
    logic signed [DATA_W-1:0]  out_z;
    logic                      factor_clamped;
  } kvi_out_t;

  typedef struct packed {
    logic [DATA_W-1:0]         t;
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [DATA_W-1:0]  z;
  } kvi_key_t;

  // search packet that moves one cell per cycle
  typedef struct packed {
    logic [DATA_W-1:0]  query;
    logic               found;
    logic               pair_valid;
    kvi_key_t           prev;
    kvi_key_t           key_a;
    kvi_key_t           key_b;
  } kvi_pkt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLS,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } kvi_state_t;

endpackage

// ----- src/kvi_if.sv -----
// Interfaces: command, result and configuration channels.
interface kvi_cmd_if;
  import kvi_pkg::*;
  logic    valid;
  logic    ready;
  kvi_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kvi_res_if;
  import kvi_pkg::*;
  logic     valid;
  logic     ready;
  kvi_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kvi_cfg_if;
  import kvi_pkg::*;
  logic            valid;
  logic            ready;
  logic [KC_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/kvi_cell.sv -----
// Key cell: holds one key and applies its step of the interval search to the passing packet.
module kvi_cell (
  input  logic                         clk,
  input  logic [kvi_pkg::IDX_W-1:0]    idx,
  input  logic [kvi_pkg::CNT_W-1:0]    n_keys,
  input  logic                         wr_en,
  input  logic [kvi_pkg::SLOT_W-1:0]   wr_slot,
  input  kvi_pkg::kvi_key_t            wr_key,
  input  kvi_pkg::kvi_pkt_t            pkt_in,
  output kvi_pkg::kvi_pkt_t            pkt_out
);
  import kvi_pkg::*;

  kvi_key_t key;
  kvi_pkt_t pkt_next;
  logic     active;
  logic     search;
  logic     hit;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_slot) == 32'(idx))) begin
      key <= wr_key;
    end
    pkt_out <= pkt_next;
  end

  always_comb begin
    active   = CNT_W'(idx) < n_keys;
    search   = active && (idx != '0);
    hit      = pkt_in.query < key.t;
    pkt_next = pkt_in;
    // first cell that sees a hit owns the interval; cell 1 also sets the fallback pair
    if (search && !pkt_in.found) begin
      if (hit || !pkt_in.pair_valid) begin
        pkt_next.key_a      = pkt_in.prev;
        pkt_next.key_b      = key;
        pkt_next.pair_valid = 1'b1;
      end
      pkt_next.found = hit;
    end
    if (active) begin
      pkt_next.prev = key;
    end
  end

endmodule

// ----- src/kvi_div.sv -----
// Restoring divider: Q1.16 quotient of a dividend no larger than the divisor, one bit per cycle.
module kvi_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [kvi_pkg::DATA_W-1:0]       dividend,
  input  logic [kvi_pkg::DATA_W-1:0]       divisor,
  output logic                             done,
  output logic [kvi_pkg::FACTOR_W-1:0]     quot
);
  import kvi_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W:0]     rem2;
  logic [DATA_W:0]     rem2_sub;
  logic                ge;
  logic                ge0;

  always_comb begin
    rem2     = {rem, 1'b0};
    rem2_sub = rem2 - {1'b0, divisor};
    ge       = rem2 >= {1'b0, divisor};
    ge0      = dividend >= divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(FRAC_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(FRAC_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // integer bit: set only when dividend equals divisor
      rem  <= ge0 ? (dividend - divisor) : dividend;
      quot <= {{(FACTOR_W-1){1'b0}}, ge0};
    end else if (busy) begin
      rem  <= ge ? rem2_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
      quot <= {quot[FACTOR_W-2:0], ge};
    end
  end

endmodule

// ----- src/kvi_lerp.sv -----
// Blend unit: one component, base + floor(factor * diff / 2^16), product registered.
module kvi_lerp (
  input  logic                                 clk,
  input  logic [kvi_pkg::FACTOR_W-1:0]         factor,
  input  logic signed [kvi_pkg::DATA_W:0]      diff,
  input  logic signed [kvi_pkg::DATA_W-1:0]    base,
  output logic signed [kvi_pkg::DATA_W-1:0]    value
);
  import kvi_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] sum;

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, factor}) * diff;
  end

  // arithmetic shift gives floor for both signs
  assign sum   = PROD_W'(base) + (prod >>> FRAC_W);
  assign value = sum[DATA_W-1:0];

endmodule

// ----- src/keyframe_vector_interpolator.sv -----
// Top level: keyframe table in a chain of key cells, serial divider and three blend units.
// A store transfer writes its key at the accepting edge and gives no result.
// A sample result registers after the walk through the MAX_KEYS cells, the classification,
// the 17-step divider when a divide is needed, and the blend multiply; the divide is skipped
// when the factor is zero or clamped. One sample is in flight; the next is accepted the cycle
// after the result registers. Reset clears control and sets key_count to 1; keys are undefined
// until stored.
module keyframe_vector_interpolator (
  input  logic      clk,
  input  logic      rst,
  kvi_cmd_if.sink   cmd,
  kvi_cfg_if.sink   cfg,
  kvi_res_if.source res
);
  import kvi_pkg::*;

  kvi_state_t                state;
  kvi_state_t                state_next;
  logic [KC_W-1:0]           key_count;
  logic [CNT_W-1:0]          n_keys;
  logic [CNT_W-1:0]          step;
  logic                      store_we;
  kvi_key_t                  wr_key;
  kvi_pkt_t                  chain [0:MAX_KEYS];
  kvi_pkt_t                  launch;
  kvi_pkt_t                  tail;
  kvi_key_t                  sel_a;
  kvi_key_t                  sel_b;

  logic signed [DATA_W-1:0]  lo_x;
  logic signed [DATA_W-1:0]  lo_y;
  logic signed [DATA_W-1:0]  lo_z;
  logic signed [DATA_W:0]    diff_x;
  logic signed [DATA_W:0]    diff_y;
  logic signed [DATA_W:0]    diff_z;
  logic signed [DATA_W:0]    num;
  logic signed [DATA_W:0]    den;
  logic signed [DATA_W:0]    num_neg;
  logic signed [DATA_W:0]    den_neg;
  logic [DATA_W-1:0]         num_abs;
  logic [DATA_W-1:0]         den_abs;
  logic                      is_zero;
  logic                      is_opp;
  logic                      is_over;
  logic                      quick;
  logic [FACTOR_W-1:0]       factor;
  logic                      clamped;

  logic                      div_start;
  logic                      div_done;
  logic [FACTOR_W-1:0]       div_quot;
  logic                      res_load;
  logic                      res_valid;
  kvi_out_t                  res_data;
  logic signed [DATA_W-1:0]  val_x;
  logic signed [DATA_W-1:0]  val_y;
  logic signed [DATA_W-1:0]  val_z;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= KC_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      key_count <= cfg.data;
    end
  end

  always_comb begin
    if (key_count == '0) begin
      n_keys = CNT_W'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n_keys = CNT_W'(MAX_KEYS);
    end else begin
      n_keys = CNT_W'(key_count);
    end
  end

  // cell chain
  assign store_we = cmd.valid && cmd.ready && (cmd.data.command == CMD_STORE);
  assign wr_key   = '{t: cmd.data.key_time, x: cmd.data.key_x,
                      y: cmd.data.key_y, z: cmd.data.key_z};
  assign chain[0] = launch;
  assign tail     = chain[MAX_KEYS];

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    kvi_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(g)),
      .n_keys  (n_keys),
      .wr_en   (store_we),
      .wr_slot (cmd.data.key_slot),
      .wr_key  (wr_key),
      .pkt_in  (chain[g]),
      .pkt_out (chain[g+1])
    );
  end

  // with a single key the pair is never set: blend key 0 with itself
  assign sel_a = tail.pair_valid ? tail.key_a : tail.prev;
  assign sel_b = tail.pair_valid ? tail.key_b : tail.prev;

  // factor classification
  always_comb begin
    num_neg = -num;
    den_neg = -den;
    num_abs = num[DATA_W] ? num_neg[DATA_W-1:0] : num[DATA_W-1:0];
    den_abs = den[DATA_W] ? den_neg[DATA_W-1:0] : den[DATA_W-1:0];
    is_zero = (num == '0) || (den == '0);
    is_opp  = num[DATA_W] != den[DATA_W];
    is_over = num_abs > den_abs;
    quick   = is_zero || is_opp || is_over;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid && (cmd.data.command == CMD_SAMPLE)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step == CNT_W'(MAX_KEYS)) begin
          state_next = ST_CLS;
        end
      end
      ST_CLS: begin
        if (quick) begin
          state_next = ST_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!res_valid || res.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_IDLE) begin
      step <= '0;
    end else if (state == ST_WALK) begin
      step <= step + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && cmd.valid && (cmd.data.command == CMD_SAMPLE)) begin
      launch <= '{query: cmd.data.query_time, default: '0};
    end
    if ((state == ST_WALK) && (step == CNT_W'(MAX_KEYS))) begin
      lo_x   <= sel_a.x;
      lo_y   <= sel_a.y;
      lo_z   <= sel_a.z;
      diff_x <= (DATA_W+1)'(sel_b.x) - (DATA_W+1)'(sel_a.x);
      diff_y <= (DATA_W+1)'(sel_b.y) - (DATA_W+1)'(sel_a.y);
      diff_z <= (DATA_W+1)'(sel_b.z) - (DATA_W+1)'(sel_a.z);
      num    <= $signed({1'b0, tail.query}) - $signed({1'b0, sel_a.t});
      den    <= $signed({1'b0, sel_b.t}) - $signed({1'b0, sel_a.t});
    end
    if (state == ST_CLS) begin
      factor  <= (is_over && !is_zero && !is_opp) ? FACTOR_ONE : '0;
      clamped <= !is_zero && (is_opp || is_over);
    end
    if ((state == ST_DIV) && div_done) begin
      factor <= div_quot;
    end
  end

  kvi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_abs),
    .divisor  (den_abs),
    .done     (div_done),
    .quot     (div_quot)
  );

  kvi_lerp u_lerp_x (.clk(clk), .factor(factor), .diff(diff_x), .base(lo_x), .value(val_x));
  kvi_lerp u_lerp_y (.clk(clk), .factor(factor), .diff(diff_y), .base(lo_y), .value(val_y));
  kvi_lerp u_lerp_z (.clk(clk), .factor(factor), .diff(diff_z), .base(lo_z), .value(val_z));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= '{out_x: val_x, out_y: val_y, out_z: val_z, factor_clamped: clamped};
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

// ----- src/kvi_checker.sv -----
// Checker: port-level properties of the interpolator, bound to the top level.
module kvi_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input kvi_pkg::kvi_cmd_t   cmd_command,
  input logic                res_valid,
  input logic                res_ready,
  input kvi_pkg::kvi_out_t   res_data
);
  import kvi_pkg::*;

  logic [1:0] pend;
  logic [1:0] pend_next;
  logic       sample_xfer;
  logic       res_xfer;

  assign sample_xfer = cmd_valid && cmd_ready && (cmd_command == CMD_SAMPLE);
  assign res_xfer    = res_valid && res_ready;

  always_comb begin
    pend_next = pend;
    if (sample_xfer && !res_xfer) begin
      pend_next = pend + 1'b1;
    end else if (!sample_xfer && res_xfer) begin
      pend_next = pend - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // a result is only shown for a sample that was taken
  a_res_has_sample: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pend != 2'd0))
    else $error("result without pending sample");

  // at most one sample in work plus one waiting result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (pend == 2'd2) |-> !cmd_ready)
    else $error("command taken with result and sample outstanding");

  // the block is busy in the cycle after a sample transfer
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> !cmd_ready)
    else $error("command ready right after sample transfer");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind keyframe_vector_interpolator kvi_checker u_kvi_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_command (cmd.data.command),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_data    (res.data)
);
